// ===== rtl/counting_semaphore_table_assert.svh =====
// assertion macros for the counting semaphore table
`ifndef COUNTING_SEMAPHORE_TABLE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
// shared types and codes of the counting semaphore table
`default_nettype none

package cst_pkg;

    // request actions
    localparam logic [2:0] ACT_CREATE    = 3'd0;
    localparam logic [2:0] ACT_TERMINATE = 3'd1;
    localparam logic [2:0] ACT_WAIT      = 3'd2;
    localparam logic [2:0] ACT_TRY_WAIT  = 3'd3;
    localparam logic [2:0] ACT_POST      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    // counter limits
    localparam logic signed [15:0] CNT_MIN = 16'sh8000;
    localparam logic signed [15:0] CNT_MAX = 16'sh7fff;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic wake;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic wake_pend;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/cst_ctrl.sv =====
// request sequencer of the counting semaphore table
`default_nettype none

module cst_ctrl
    import cst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAKE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.wake_pend ? S_WAKE : S_IDLE;
            end
            S_WAKE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_busy     = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.wake = (r_state == S_WAKE);

endmodule

`default_nettype wire

// ===== rtl/cst_datapath.sv =====
// slot memories, wait queues and update logic of the counting semaphore table
`default_nettype none

module cst_datapath
    import cst_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 16,
    parameter int QUEUE_DEPTH    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [2:0]         i_action,
    input  wire logic [3:0]         i_sem_index,
    input  wire logic [15:0]        i_process_id,
    input  wire logic signed [15:0] i_initial_value,
    output t_dp_stat                o_stat,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic                    o_caller_blocked,
    output logic                    o_woken_valid,
    output logic [15:0]             o_woken_pid
);

    localparam int SLOT_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int QTOT   = NUM_SEMAPHORES * QUEUE_DEPTH;
    localparam int QA     = (QTOT > 1) ? $clog2(QTOT) : 1;

    // slot state memories and valid bits
    logic signed [15:0] r_cnt_mem  [NUM_SEMAPHORES];
    logic [QW-1:0]      r_head_mem [NUM_SEMAPHORES];
    logic [CW-1:0]      r_qcnt_mem [NUM_SEMAPHORES];
    logic [15:0]        r_queue_mem[QTOT];
    logic [NUM_SEMAPHORES-1:0] r_slot_valid;

    // latched request and slot read data
    logic [2:0]         r_act;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_in_range;
    logic [15:0]        r_pid;
    logic signed [15:0] r_init;
    logic signed [15:0] r_cnt;
    logic [QW-1:0]      r_head;
    logic [CW-1:0]      r_qcnt;
    logic [15:0]        r_qdata;

    // result registers
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic               r_blocked;
    logic               r_woken;
    logic [15:0]        r_woken_pid;

    // update decision
    logic               n_status_ok;
    logic [1:0]         n_status;
    logic               n_blocked;
    logic               wake;
    logic               slot_we;
    logic signed [15:0] wr_cnt;
    logic [QW-1:0]      wr_head;
    logic [CW-1:0]      wr_qcnt;
    logic               set_valid;
    logic               clr_valid;
    logic               q_we;
    logic               cur_valid;
    logic [QW:0]        tail_sum;
    logic [QW-1:0]      tail_pos;
    logic [QW-1:0]      head_next;
    logic [QA-1:0]      q_addr;

    assign cur_valid = r_slot_valid[r_slot];

    // tail slot of the ring and the head after a pop
    assign tail_sum  = (QW+1)'(r_head) + (QW+1)'(r_qcnt);
    assign tail_pos  = (tail_sum >= (QW+1)'(QUEUE_DEPTH))
                     ? QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign head_next = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);

    // queue address: slot base plus ring position
    assign q_addr = QA'(QA'(r_slot) * QA'(QUEUE_DEPTH)) + QA'(wake ? r_head : tail_pos);

    always_comb begin
        n_status_ok = 1'b0;
        n_status    = ST_ERR;
        n_blocked   = 1'b0;
        wake        = 1'b0;
        slot_we     = 1'b0;
        wr_cnt      = r_cnt;
        wr_head     = r_head;
        wr_qcnt     = r_qcnt;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        q_we        = 1'b0;
        if (r_in_range) begin
            unique case (r_act)
                ACT_CREATE: begin
                    if (!cur_valid) begin
                        n_status_ok = 1'b1;
                        set_valid   = 1'b1;
                        slot_we     = 1'b1;
                        wr_cnt      = r_init;
                        wr_head     = '0;
                        wr_qcnt     = '0;
                    end
                end
                ACT_TERMINATE: begin
                    if (cur_valid) begin
                        n_status_ok = 1'b1;
                        clr_valid   = 1'b1;
                    end
                end
                ACT_WAIT: begin
                    if (cur_valid && r_cnt != CNT_MIN) begin
                        if (r_cnt <= 16'sd0) begin
                            // caller sleeps unless its queue is full
                            if (r_qcnt < CW'(QUEUE_DEPTH)) begin
                                n_status_ok = 1'b1;
                                n_blocked   = 1'b1;
                                slot_we     = 1'b1;
                                q_we        = 1'b1;
                                wr_cnt      = r_cnt - 16'sd1;
                                wr_qcnt     = r_qcnt + CW'(1);
                            end
                        end else begin
                            n_status_ok = 1'b1;
                            slot_we     = 1'b1;
                            wr_cnt      = r_cnt - 16'sd1;
                        end
                    end
                end
                ACT_TRY_WAIT: begin
                    if (cur_valid) begin
                        if (r_cnt > 16'sd0) begin
                            n_status_ok = 1'b1;
                            slot_we     = 1'b1;
                            wr_cnt      = r_cnt - 16'sd1;
                        end else begin
                            n_status = ST_BUSY;
                        end
                    end
                end
                ACT_POST: begin
                    if (cur_valid && r_cnt != CNT_MAX) begin
                        n_status_ok = 1'b1;
                        slot_we     = 1'b1;
                        wr_cnt      = r_cnt + 16'sd1;
                        // wake the oldest sleeper
                        if (r_cnt < 16'sd0 && r_qcnt != '0) begin
                            wake    = 1'b1;
                            wr_head = head_next;
                            wr_qcnt = r_qcnt - CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (n_status_ok) n_status = ST_OK;
    end

    assign o_stat.wake_pend = wake;

    // request latch and slot memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_slot     <= SLOT_W'(i_sem_index);
            r_in_range <= (32'(i_sem_index) < NUM_SEMAPHORES);
            r_pid      <= i_process_id;
            r_init     <= i_initial_value;
            r_cnt      <= r_cnt_mem[SLOT_W'(i_sem_index)];
            r_head     <= r_head_mem[SLOT_W'(i_sem_index)];
            r_qcnt     <= r_qcnt_mem[SLOT_W'(i_sem_index)];
        end
        if (i_cmd.exec && slot_we) begin
            r_cnt_mem[r_slot]  <= wr_cnt;
            r_head_mem[r_slot] <= wr_head;
            r_qcnt_mem[r_slot] <= wr_qcnt;
        end
    end

    // wait queue memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (q_we) r_queue_mem[q_addr] <= r_pid;
            r_qdata <= r_queue_mem[q_addr];
        end
    end

    // slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (i_cmd.exec) begin
            if (set_valid) r_slot_valid[r_slot] <= 1'b1;
            if (clr_valid) r_slot_valid[r_slot] <= 1'b0;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_cmd.exec && !wake) || i_cmd.wake;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_blocked   <= n_blocked;
            r_woken     <= wake;
            r_woken_pid <= '0;
        end else if (i_cmd.wake) begin
            r_woken_pid <= r_qdata;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_caller_blocked = r_blocked;
    assign o_woken_valid    = r_woken;
    assign o_woken_pid      = r_woken_pid;

endmodule

`default_nettype wire

// ===== rtl/counting_semaphore_table.sv =====
// counting semaphore table: one request per word; the result is registered at the end
// of the execute state, or of an extra wake state for a post that wakes a sleeper
// (extra queue memory read). busy stays high until the result is registered, so a new
// word waits until the last is through; the slot memory read-modify-write sets this.
// synchronous active-low reset clears the slot valid bits, the sequencer and the strobe;
// the receiver cannot stall, each result is shown for exactly one cycle.
`default_nettype none

module counting_semaphore_table
    import cst_pkg::*;
#(
    parameter int NUM_SEMAPHORES = 16,
    parameter int QUEUE_DEPTH    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_action,
    input  wire logic [3:0]         i_sem_index,
    input  wire logic [15:0]        i_process_id,
    input  wire logic signed [15:0] i_initial_value,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic                    o_caller_blocked,
    output logic                    o_woken_valid,
    output logic [15:0]             o_woken_pid
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    cst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // storage and update logic
    cst_datapath #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_sem_index      (i_sem_index),
        .i_process_id     (i_process_id),
        .i_initial_value  (i_initial_value),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_caller_blocked (o_caller_blocked),
        .o_woken_valid    (o_woken_valid),
        .o_woken_pid      (o_woken_pid)
    );

    // checks
`include "counting_semaphore_table_assert.svh"

    `CST_ASSERT_IMPL(a_strobe_idle, o_valid, !busy, "result shown while still busy")
    `CST_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !o_valid, "accept did not start work")
    `CST_ASSERT_NEXT(a_strobe_once, o_valid, !o_valid, "result strobe longer than one cycle")
    `CST_ASSERT_IMPL(a_wake_ok, o_valid && o_woken_valid, o_status == ST_OK && !o_caller_blocked, "wake with bad status")

endmodule

`default_nettype wire

// ===== tb/counting_semaphore_table_test.sv =====
// self-checking testbench for the counting semaphore table
`default_nettype none

module counting_semaphore_table_test;
    import cst_pkg::*;

    localparam int SLOT_COUNT     = 16;
    localparam int SLEEPER_DEPTH  = 16;
    localparam int RANDOM_WORDS   = 1800;
    localparam int STALL_LIMIT    = 600;
    localparam int SETTLE_CYCLES  = 8;

    // action codes the block does not define, all answered with an error
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         sem_index;
        logic [15:0]        process_id;
        logic signed [15:0] initial_value;
    } sem_request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        blocked;
        logic        woken_valid;
        logic [15:0] woken_pid;
    } sem_outcome_t;

    typedef struct packed {
        sem_request_t req;
        logic         typed;
        sem_outcome_t outcome;
    } sem_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_action = ACT_CREATE;
    logic [3:0]         i_sem_index = '0;
    logic [15:0]        i_process_id = '0;
    logic signed [15:0] i_initial_value = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic               o_caller_blocked;
    logic               o_woken_valid;
    logic [15:0]        o_woken_pid;

    counting_semaphore_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_sem_index      (i_sem_index),
        .i_process_id     (i_process_id),
        .i_initial_value  (i_initial_value),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_caller_blocked (o_caller_blocked),
        .o_woken_valid    (o_woken_valid),
        .o_woken_pid      (o_woken_pid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the semaphore table
    bit                 slot_live   [SLOT_COUNT];
    logic signed [15:0] sem_count   [SLOT_COUNT];
    logic [15:0]        sleeper_fifo[SLOT_COUNT][SLEEPER_DEPTH];
    logic [3:0]         fifo_head   [SLOT_COUNT];
    logic [4:0]         fifo_fill   [SLOT_COUNT];

    sem_outcome_t outcomes_due[$];
    sem_row_t     directed_rows[$];
    int           fail_count = 0;
    int           words_sent = 0;
    int           quiet_left = 0;
    int           stall_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t on %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // apply one request to the shadow table and return its outcome
    function automatic sem_outcome_t apply_sem_request(sem_request_t r);
        sem_outcome_t res;
        logic [3:0] slot;
        logic signed [15:0] c;
        logic [3:0] tail;
        res = '{ST_ERR, 1'b0, 1'b0, 16'h0};
        slot = r.sem_index;
        c = sem_count[slot];
        case (r.action)
            ACT_CREATE: begin
                if (!slot_live[slot]) begin
                    slot_live[slot] = 1'b1;
                    sem_count[slot] = r.initial_value;
                    fifo_head[slot] = '0;
                    fifo_fill[slot] = '0;
                    res.status = ST_OK;
                end
            end
            ACT_TERMINATE: begin
                if (slot_live[slot]) begin
                    slot_live[slot] = 1'b0;
                    fifo_head[slot] = '0;
                    fifo_fill[slot] = '0;
                    res.status = ST_OK;
                end
            end
            ACT_WAIT: begin
                if (slot_live[slot] && c != CNT_MIN) begin
                    if (c <= 0) begin
                        // caller sleeps unless the queue is already full
                        if (fifo_fill[slot] < SLEEPER_DEPTH) begin
                            tail = fifo_head[slot] + fifo_fill[slot][3:0];
                            sleeper_fifo[slot][tail] = r.process_id;
                            fifo_fill[slot] = fifo_fill[slot] + 5'd1;
                            sem_count[slot] = c - 16'sd1;
                            res.status = ST_OK;
                            res.blocked = 1'b1;
                        end
                    end else begin
                        sem_count[slot] = c - 16'sd1;
                        res.status = ST_OK;
                    end
                end
            end
            ACT_TRY_WAIT: begin
                if (slot_live[slot]) begin
                    if (c > 0) begin
                        sem_count[slot] = c - 16'sd1;
                        res.status = ST_OK;
                    end else begin
                        res.status = ST_BUSY;
                    end
                end
            end
            ACT_POST: begin
                if (slot_live[slot] && c != CNT_MAX) begin
                    // oldest sleeper wakes only while the count is negative
                    if (c < 0 && fifo_fill[slot] != 0) begin
                        res.woken_valid = 1'b1;
                        res.woken_pid = sleeper_fifo[slot][fifo_head[slot]];
                        fifo_head[slot] = fifo_head[slot] + 4'd1;
                        fifo_fill[slot] = fifo_fill[slot] - 5'd1;
                    end
                    sem_count[slot] = c + 16'sd1;
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // sender idle length: mostly none or short, a few long, some quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic sem_request_t random_request();
        sem_request_t r;
        int a;
        int k;
        a = $urandom_range(0, 99);
        if (a < 14) r.action = ACT_CREATE;
        else if (a < 20) r.action = ACT_TERMINATE;
        else if (a < 48) r.action = ACT_WAIT;
        else if (a < 62) r.action = ACT_TRY_WAIT;
        else if (a < 95) r.action = ACT_POST;
        else if (a < 97) r.action = ACT_SPARE_5;
        else if (a < 99) r.action = ACT_SPARE_6;
        else r.action = ACT_SPARE_7;
        // most traffic on a few slots so their state gets deep
        if ($urandom_range(0, 99) < 85) r.sem_index = 4'($urandom_range(0, 3));
        else r.sem_index = 4'($urandom_range(0, SLOT_COUNT - 1));
        r.process_id = 16'($urandom_range(0, 65535));
        k = $urandom_range(0, 9);
        if (r.action != ACT_CREATE || k == 2) r.initial_value = 16'($urandom_range(0, 65535));
        else if (k == 0) r.initial_value = CNT_MAX - 16'($urandom_range(0, 2));
        else if (k == 1) r.initial_value = CNT_MIN + 16'($urandom_range(0, 2));
        else r.initial_value = 16'(int'($urandom_range(0, 6)) - 3);
        return r;
    endfunction

    // hand one word to the block and log its outcome once accepted
    task automatic send_word(input sem_request_t r, input int gap, input bit drain,
                             input logic typed, input sem_outcome_t typed_outcome);
        sem_outcome_t predicted;
        if (drain && gap == 0) gap = 1;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            while (drain && outcomes_due.size() != 0) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= r.action;
        i_sem_index <= r.sem_index;
        i_process_id <= r.process_id;
        i_initial_value <= r.initial_value;
        do @(posedge i_clk); while (busy);
        predicted = apply_sem_request(r);
        outcomes_due.push_back(typed ? typed_outcome : predicted);
        words_sent++;
    endtask

    task automatic add_row(input logic [2:0] act, input logic [3:0] idx,
                           input logic [15:0] pid, input logic signed [15:0] init,
                           input logic typed, input logic [1:0] st, input logic blk,
                           input logic wv, input logic [15:0] wpid);
        sem_row_t row;
        row.req = '{act, idx, pid, init};
        row.typed = typed;
        row.outcome = '{st, blk, wv, wpid};
        directed_rows.push_back(row);
    endtask

    // fill one queue past its depth, then drain it with posts
    task automatic run_fill_burst();
        sem_request_t r;
        int n;
        r = random_request();
        r.sem_index = 4'($urandom_range(0, SLOT_COUNT - 1));
        r.action = ACT_TERMINATE;
        send_word(r, pick_gap(), 1'b0, 1'b0, '0);
        r.action = ACT_CREATE;
        r.initial_value = 16'(int'($urandom_range(0, 3)) - 2);
        send_word(r, pick_gap(), 1'b0, 1'b0, '0);
        n = $urandom_range(SLEEPER_DEPTH, SLEEPER_DEPTH + 3);
        r.action = ACT_WAIT;
        repeat (n) begin
            r.process_id = 16'($urandom_range(0, 65535));
            send_word(r, pick_gap(), 1'b0, 1'b0, '0);
        end
        repeat (n + 2) begin
            r.action = ($urandom_range(0, 9) == 0) ? ACT_TRY_WAIT : ACT_POST;
            r.initial_value = 16'($urandom_range(0, 65535));
            send_word(r, pick_gap(), 1'b0, 1'b0, '0);
        end
    endtask

    // result checker: one word per strobe against the oldest expectation
    always @(posedge i_clk) begin : check_outcomes
        sem_outcome_t want;
        if (i_rst_n && o_valid) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("word with nothing expected", o_status, -1);
            end else begin
                want = outcomes_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_caller_blocked !== want.blocked)
                    report_mismatch("caller_blocked", o_caller_blocked, want.blocked);
                if (o_woken_valid !== want.woken_valid)
                    report_mismatch("woken_valid", o_woken_valid, want.woken_valid);
                if (o_woken_pid !== want.woken_pid)
                    report_mismatch("woken_pid", o_woken_pid, want.woken_pid);
            end
        end
    end

    // watchdog on cycles where no word moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        sem_request_t r;
        bit drain;
        // directed: act, slot, pid, init, typed, status, blocked, woken, woken pid
        add_row(ACT_WAIT,      4'd0,  16'h1234, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_POST,      4'd15, 16'h0000, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_TRY_WAIT,  4'd3,  16'hffff, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_TERMINATE, 4'd7,  16'h0001, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_SPARE_5,   4'd0,  16'h0000, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_SPARE_6,   4'd0,  16'h0000, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_SPARE_7,   4'd0,  16'h0000, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_CREATE,    4'd0,  16'h0000, CNT_MAX, 1'b1, ST_OK,  1'b0, 1'b0, 16'h0);
        add_row(ACT_CREATE,    4'd0,  16'h0000, 16'sd5, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_POST,      4'd0,  16'h0000, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_TRY_WAIT,  4'd0,  16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_CREATE,    4'd1,  16'h0000, CNT_MIN, 1'b1, ST_OK,  1'b0, 1'b0, 16'h0);
        add_row(ACT_WAIT,      4'd1,  16'h00aa, 16'sd0, 1'b1, ST_ERR,  1'b0, 1'b0, 16'h0);
        add_row(ACT_TRY_WAIT,  4'd1,  16'h0000, 16'sd0, 1'b1, ST_BUSY, 1'b0, 1'b0, 16'h0);
        add_row(ACT_POST,      4'd1,  16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_CREATE,    4'd15, 16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_WAIT,      4'd15, 16'hffff, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_WAIT,      4'd15, 16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_POST,      4'd15, 16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_POST,      4'd15, 16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_POST,      4'd15, 16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_WAIT,      4'd15, 16'h5a5a, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_WAIT,      4'd15, 16'ha5a5, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_TERMINATE, 4'd15, 16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);
        add_row(ACT_TERMINATE, 4'd0,  16'h0000, 16'sd0, 1'b0, ST_OK,   1'b0, 1'b0, 16'h0);

        // reset held from the start, released on a clock edge
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].req, pick_gap(), 1'b0,
                      directed_rows[i].typed, directed_rows[i].outcome);

        // random part, first word waits for the pipeline to empty
        drain = 1'b1;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 4) begin
                run_fill_burst();
            end else begin
                r = random_request();
                send_word(r, pick_gap(), drain, 1'b0, '0);
                drain = ($urandom_range(0, 149) == 0);
            end
        end

        start <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== counting_semaphore_table.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_ctrl.sv
rtl/cst_datapath.sv
rtl/counting_semaphore_table.sv
tb/counting_semaphore_table_test.sv
